[design/ncpu_pkg.sv]
// Shared types and constants for the nibble CPU execute step.
// Used by every module in the design folder; depends on nothing.
package ncpu_pkg;

   localparam int RAM_WORDS_DEFAULT = 14;

   localparam logic [3:0] ADDR_IN  = 4'd15;
   localparam logic [3:0] ADDR_OUT = 4'd14;

   typedef enum logic [3:0] {
      OP_HALT = 4'd0,
      OP_ADD  = 4'd1,
      OP_ADIF = 4'd2,
      OP_LAM  = 4'd3,
      OP_LAI  = 4'd4,
      OP_JZ   = 4'd5,
      OP_LBI  = 4'd6,
      OP_LBM  = 4'd7,
      OP_JMP  = 4'd8,
      OP_STO  = 4'd9,
      OP_AND  = 4'd10,
      OP_OR   = 4'd11,
      OP_XOR  = 4'd12,
      OP_NAND = 4'd13,
      OP_NOR  = 4'd14,
      OP_XNOR = 4'd15
   } opcode_type;

   typedef struct packed {
      logic [7:0] instruction;
      logic       input_valid;
      logic [3:0] input_value;
   } req_word_type;

   typedef struct packed {
      logic [3:0] next_pc;
      logic       halted;
      logic [3:0] out_value;
      logic       out_strobe;
      logic [3:0] acc_a;
      logic [3:0] acc_b;
      logic [3:0] alu_out;
   } rsp_word_type;

   typedef struct packed {
      logic [3:0] reg_a;
      logic [3:0] reg_b;
      logic [3:0] reg_o;
      logic [3:0] pc;
      logic [3:0] in_latch;
      logic [3:0] out_latch;
      logic       halt;
   } arch_state_type;

   typedef struct packed {
      logic       en;
      logic [3:0] addr;
      logic [3:0] data;
   } mem_write_type;

endpackage

[design/ncpu_datamem.sv]
// Data RAM of the nibble CPU: RAM_WORDS nibbles, cleared by reset.
// Depends on ncpu_pkg. Addresses at or beyond RAM_WORDS read as zero.
module ncpu_datamem #(
   parameter int RAM_WORDS = ncpu_pkg::RAM_WORDS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ncpu_pkg::mem_write_type wr,
   input  logic [3:0]             rd_addr,
   output logic [3:0]             rd_data
);
   import ncpu_pkg::*;

   localparam int         IDX_W = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
   localparam logic [3:0] DEPTH = 4'(RAM_WORDS);

   logic [3:0] mem_ff [RAM_WORDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RAM_WORDS; i++) begin
            mem_ff[i] <= 4'd0;
         end
      end else if (wr.en && (wr.addr < DEPTH)) begin
         mem_ff[wr.addr[IDX_W-1:0]] <= wr.data;
      end
   end

   assign rd_data = (rd_addr < DEPTH) ? mem_ff[rd_addr[IDX_W-1:0]] : 4'd0;

endmodule

[design/ncpu_exec.sv]
// Instruction decode and 4-bit ALU: next architectural state from one word.
// Depends on ncpu_pkg. Purely combinational.
module ncpu_exec (
   input  ncpu_pkg::req_word_type   req,
   input  ncpu_pkg::arch_state_type cur,
   input  logic [3:0]               mem_rd_data,
   output ncpu_pkg::arch_state_type nxt,
   output ncpu_pkg::mem_write_type  mem_wr,
   output ncpu_pkg::rsp_word_type   rsp
);
   import ncpu_pkg::*;

   opcode_type op;
   logic [3:0] operand;
   logic [3:0] load_val;
   logic       jumped;
   logic       strobe;

   assign op      = opcode_type'(req.instruction[7:4]);
   assign operand = req.instruction[3:0];

   // I/O addresses shadow the RAM
   always_comb begin
      if (operand == ADDR_IN) begin
         load_val = cur.in_latch;
      end else if (operand == ADDR_OUT) begin
         load_val = cur.out_latch;
      end else begin
         load_val = mem_rd_data;
      end
   end

   always_comb begin
      nxt    = cur;
      mem_wr = '0;
      jumped = 1'b0;
      strobe = 1'b0;
      if (!cur.halt) begin
         unique case (op)
            OP_HALT: nxt.halt  = 1'b1;
            OP_ADD:  nxt.reg_o = cur.reg_a + cur.reg_b;
            OP_ADIF: nxt.reg_o = (cur.reg_a >= cur.reg_b) ? cur.reg_a - cur.reg_b
                                                           : cur.reg_b - cur.reg_a;
            OP_LAM:  nxt.reg_a = load_val;
            OP_LAI:  nxt.reg_a = operand;
            OP_JZ: begin
               if (cur.reg_a == 4'd0) begin
                  nxt.pc = operand;
                  jumped = 1'b1;
               end
            end
            OP_LBI:  nxt.reg_b = operand;
            OP_LBM:  nxt.reg_b = load_val;
            OP_JMP: begin
               nxt.pc = operand;
               jumped = 1'b1;
            end
            OP_STO: begin
               if (operand == ADDR_IN) begin
                  nxt.in_latch = cur.reg_o;
               end else if (operand == ADDR_OUT) begin
                  nxt.out_latch = cur.reg_o;
                  strobe        = 1'b1;
               end else begin
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = operand;
                  mem_wr.data = cur.reg_o;
               end
            end
            OP_AND:  nxt.reg_o = cur.reg_a & cur.reg_b;
            OP_OR:   nxt.reg_o = cur.reg_a | cur.reg_b;
            OP_XOR:  nxt.reg_o = cur.reg_a ^ cur.reg_b;
            OP_NAND: nxt.reg_o = ~(cur.reg_a & cur.reg_b);
            OP_NOR:  nxt.reg_o = ~(cur.reg_a | cur.reg_b);
            OP_XNOR: nxt.reg_o = ~(cur.reg_a ^ cur.reg_b);
         endcase
         if (!jumped) begin
            nxt.pc = cur.pc + 4'd1;
         end
         // new input lands after the instruction, over any store to it
         if (req.input_valid) begin
            nxt.in_latch = req.input_value;
         end
      end
   end

   always_comb begin
      rsp.next_pc    = nxt.pc;
      rsp.halted     = nxt.halt;
      rsp.out_value  = nxt.out_latch;
      rsp.out_strobe = strobe;
      rsp.acc_a      = nxt.reg_a;
      rsp.acc_b      = nxt.reg_b;
      rsp.alu_out    = nxt.reg_o;
   end

endmodule

[design/ncpu_rsp_queue.sv]
// Two-entry result queue (head register plus skid) for the response channel.
// Depends on ncpu_pkg. Full only when the skid entry is occupied.
module ncpu_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ncpu_pkg::rsp_word_type push_word,
   output logic                   full,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ncpu_pkg::rsp_word_type rsp_word
);
   import ncpu_pkg::*;

   logic         head_valid_ff, head_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type head_ff, head_in;
   rsp_word_type skid_ff, skid_in;
   logic         pop;

   assign pop = head_valid_ff && !rsp_stall;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            head_in = push_word;
         end else begin
            head_valid_in = 1'b0;
         end
         if (skid_valid_ff && push) begin
            skid_in       = push_word;
            skid_valid_in = 1'b1;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_in       = push_word;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = push_word;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = head_valid_ff;
   assign rsp_word  = head_ff;

`ifndef SYNTHESIS
   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry occupied while head is empty");

   a_stalled_head_holds: assert property (@(posedge clock) disable iff (reset)
      (head_valid_ff && rsp_stall) |=> head_valid_ff)
      else $error("stalled head word dropped");

   a_skid_drains_to_head: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (head_valid_ff && !skid_valid_ff))
      else $error("skid word not moved to head on pop");
`endif

endmodule

[design/nibble_cpu_execute_step.sv]
// Nibble CPU execute step: one 8-bit instruction per accepted word.
// The result word is registered in the result queue and offered once earlier results have left it.
// Throughput: one instruction per cycle while the result queue is not full; architectural state updates at accept.
// A two-entry result queue lets requests flow while one result waits.
// Reset (synchronous, active high) zeroes A, B, O, pc, I/O latches, RAM, halt.
// Depends on ncpu_pkg, ncpu_exec, ncpu_datamem and ncpu_rsp_queue.
module nibble_cpu_execute_step #(
   parameter int RAM_WORDS = ncpu_pkg::RAM_WORDS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ncpu_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ncpu_pkg::rsp_word_type rsp_word
);
   import ncpu_pkg::*;

   arch_state_type state_ff, state_in;
   mem_write_type  mem_wr;
   mem_write_type  mem_wr_gated;
   rsp_word_type   exec_rsp;
   logic [3:0]     mem_rd_data;
   logic           req_accept;
   logic           queue_full;

   // Stall only when both queue entries hold undelivered words
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;

   // Decode and execute against the current state in a single pass
   ncpu_exec u_exec (
      .req         (req_word),
      .cur         (state_ff),
      .mem_rd_data (mem_rd_data),
      .nxt         (state_in),
      .mem_wr      (mem_wr),
      .rsp         (exec_rsp)
   );

   // Write the RAM only for a word that is really taken
   always_comb begin
      mem_wr_gated    = mem_wr;
      mem_wr_gated.en = mem_wr.en && req_accept;
   end

   ncpu_datamem #(
      .RAM_WORDS (RAM_WORDS)
   ) u_datamem (
      .clock   (clock),
      .reset   (reset),
      .wr      (mem_wr_gated),
      .rd_addr (req_word.instruction[3:0]),
      .rd_data (mem_rd_data)
   );

   // Architectural registers: advance on every accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   ncpu_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_word (exec_rsp),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

`ifndef SYNTHESIS
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.halt |=> state_ff.halt)
      else $error("halt flag cleared without reset");

   a_halted_state_frozen: assert property (@(posedge clock) disable iff (reset)
      state_ff.halt |=> $stable(state_ff))
      else $error("architectural state changed after halt");

   a_strobe_not_halted: assert property (@(posedge clock) disable iff (reset)
      (req_accept && exec_rsp.out_strobe) |-> (!state_ff.halt && !exec_rsp.halted))
      else $error("output strobe raised by a halted step");
`endif

endmodule

[sim/tb_nibble_cpu_execute_step.sv]
`timescale 1ns / 100ps
// Self-checking bench for nibble_cpu_execute_step: directed and random instruction words.
// Depends on ncpu_pkg and the design; keeps its own model of the nibble machine.
module tb_nibble_cpu_execute_step;
   import ncpu_pkg::*;

   localparam int RAM_WORDS   = RAM_WORDS_DEFAULT;
   // cycles without any handshake before the run is declared hung
   localparam int STALL_LIMIT = 2000;
   // receiver hold-off used to fill the result queue and stall the input side
   localparam int HOLD_CYCLES = 60;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // machine model: registers, latches and halt flag, plus the data RAM
   arch_state_type cpu = '0;
   logic [3:0]     cpu_ram [RAM_WORDS];

   // register snapshots the design must report, oldest first
   rsp_word_type expected_states [$];

   int  words_sent      = 0;
   int  results_checked = 0;
   int  strobes_seen    = 0;
   int  mismatches      = 0;
   int  idle_cycles     = 0;
   // steady_mode: neither side idles; hold_requests: bump to start a hold-off
   bit  steady_mode     = 1'b0;
   int  hold_requests   = 0;
   int  holds_served    = 0;
   int  hold_left       = 0;

   always #5 clock = ~clock;

   nibble_cpu_execute_step #(
      .RAM_WORDS(RAM_WORDS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   // ------------------------------------------------------------------
   // Machine model
   // ------------------------------------------------------------------

   // Address 15 is the input latch, 14 the output latch; RAM beyond its
   // size reads as zero.
   function automatic logic [3:0] read_nibble(input logic [3:0] addr);
      if (addr == ADDR_IN) return cpu.in_latch;
      if (addr == ADDR_OUT) return cpu.out_latch;
      if (addr < RAM_WORDS) return cpu_ram[addr];
      return 4'd0;
   endfunction

   // Execute one instruction word on the model and return the state the
   // design must report for it.
   function automatic rsp_word_type execute_instruction(input req_word_type w);
      opcode_type   op;
      logic [3:0]   n;
      logic         strobe;
      logic         jumped;
      rsp_word_type r;
      op     = opcode_type'(w.instruction[7:4]);
      n      = w.instruction[3:0];
      strobe = 1'b0;
      jumped = 1'b0;
      // once halted, the machine holds everything, input latch included
      if (!cpu.halt) begin
         case (op)
            OP_HALT: cpu.halt  = 1'b1;
            OP_ADD:  cpu.reg_o = cpu.reg_a + cpu.reg_b;
            OP_ADIF: cpu.reg_o = (cpu.reg_a >= cpu.reg_b) ? cpu.reg_a - cpu.reg_b
                                                          : cpu.reg_b - cpu.reg_a;
            OP_LAM:  cpu.reg_a = read_nibble(n);
            OP_LAI:  cpu.reg_a = n;
            OP_JZ: begin
               if (cpu.reg_a == 4'd0) begin
                  cpu.pc = n;
                  jumped = 1'b1;
               end
            end
            OP_LBI:  cpu.reg_b = n;
            // loads B for the I/O addresses too
            OP_LBM:  cpu.reg_b = read_nibble(n);
            OP_JMP: begin
               cpu.pc = n;
               jumped = 1'b1;
            end
            OP_STO: begin
               if (n == ADDR_IN) begin
                  cpu.in_latch = cpu.reg_o;
               end else if (n == ADDR_OUT) begin
                  cpu.out_latch = cpu.reg_o;
                  strobe        = 1'b1;
               end else if (n < RAM_WORDS) begin
                  cpu_ram[n] = cpu.reg_o;
               end
            end
            // complements stay within the nibble
            OP_AND:  cpu.reg_o = cpu.reg_a & cpu.reg_b;
            OP_OR:   cpu.reg_o = cpu.reg_a | cpu.reg_b;
            OP_XOR:  cpu.reg_o = cpu.reg_a ^ cpu.reg_b;
            OP_NAND: cpu.reg_o = ~(cpu.reg_a & cpu.reg_b);
            OP_NOR:  cpu.reg_o = ~(cpu.reg_a | cpu.reg_b);
            OP_XNOR: cpu.reg_o = ~(cpu.reg_a ^ cpu.reg_b);
         endcase
         // halt still advances the counter, wrapping modulo 16
         if (!jumped) cpu.pc = cpu.pc + 4'd1;
         // a new input lands after the instruction, over a store to 15
         if (w.input_valid) cpu.in_latch = w.input_value;
      end
      r.next_pc    = cpu.pc;
      r.halted     = cpu.halt;
      r.out_value  = cpu.out_latch;
      r.out_strobe = strobe;
      r.acc_a      = cpu.reg_a;
      r.acc_b      = cpu.reg_b;
      r.alu_out    = cpu.reg_o;
      return r;
   endfunction

   function automatic logic [7:0] encode(input opcode_type op, input logic [3:0] n);
      return {op, n};
   endfunction

   // Any opcode but halt, which has to stay for the very end of the run.
   function automatic logic [7:0] random_instruction();
      opcode_type op;
      op = opcode_type'($urandom_range(int'(OP_ADD), int'(OP_XNOR)));
      return encode(op, 4'($urandom_range(0, 15)));
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one word, optionally after a random gap, and wait for it to be
   // taken. Valid stays high on return so back-to-back words need no drop.
   task automatic send_word(input logic [7:0] instr, input logic in_valid,
                            input logic [3:0] in_value);
      req_word_type w;
      w.instruction = instr;
      w.input_valid = in_valid;
      w.input_value = in_value;
      // idle each cycle with the same odds, so gaps come in random lengths
      if (!steady_mode) begin
         while ($urandom_range(0, 99) < 37) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      // accepted at this edge: advance the model
      expected_states.push_back(execute_instruction(w));
      words_sent++;
   endtask

   task automatic issue(input opcode_type op, input logic [3:0] n);
      send_word(encode(op, n), 1'b0, 4'd0);
   endtask

   // ------------------------------------------------------------------
   // Response side: random stall, hold-off on request, and the check
   // ------------------------------------------------------------------

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_result(input rsp_word_type got);
      rsp_word_type want;
      if (expected_states.size() == 0) begin
         $display("%0t ns: result word with none expected, expected nothing, actual %h",
                  $time, got);
         mismatches++;
      end else begin
         want = expected_states.pop_front();
         compare_field("next_pc",    32'(want.next_pc),    32'(got.next_pc));
         compare_field("halted",     32'(want.halted),     32'(got.halted));
         compare_field("out_value",  32'(want.out_value),  32'(got.out_value));
         compare_field("out_strobe", 32'(want.out_strobe), 32'(got.out_strobe));
         compare_field("acc_a",      32'(want.acc_a),      32'(got.acc_a));
         compare_field("acc_b",      32'(want.acc_b),      32'(got.acc_b));
         compare_field("alu_out",    32'(want.alu_out),    32'(got.alu_out));
         if (got.out_strobe) strobes_seen++;
         results_checked++;
      end
   endtask

   always @(posedge clock) begin
      // values read here are the ones present before this edge
      if (!reset && rsp_valid && !rsp_stall) check_result(rsp_word);
      // start a hold-off when the test asks for one, then count it down
      if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left    = HOLD_CYCLES;
      end
      rsp_stall <= (hold_left > 0) || (!steady_mode && $urandom_range(0, 99) < 37);
      if (hold_left > 0) hold_left--;
   end

   // Watchdog: end the run if neither channel moves a word for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Immediate loads, wrap on add, absolute difference both ways.
   task automatic test_arithmetic();
      issue(OP_ADD, 4'd0);
      issue(OP_LAI, 4'd15);
      issue(OP_LBI, 4'd15);
      issue(OP_ADD, 4'd3);
      issue(OP_ADIF, 4'd0);
      issue(OP_LAI, 4'd2);
      issue(OP_ADIF, 4'd15);
   endtask

   // All six logic ops on 1100 and 1010; complements must stay 4 bits.
   task automatic test_logic();
      issue(OP_LAI, 4'd12);
      issue(OP_LBI, 4'd10);
      issue(OP_AND, 4'd0);
      issue(OP_OR, 4'd5);
      issue(OP_XOR, 4'd10);
      issue(OP_NAND, 4'd0);
      issue(OP_NOR, 4'd0);
      issue(OP_XNOR, 4'd15);
   endtask

   // RAM store and read back through A and B, first and last word.
   task automatic test_memory();
      issue(OP_STO, 4'd0);
      issue(OP_LAM, 4'd0);
      issue(OP_STO, 4'(RAM_WORDS - 1));
      issue(OP_LBM, 4'(RAM_WORDS - 1));
   endtask

   // Output strobe, latch reads, store to the input latch with and
   // without a new input on the same step.
   task automatic test_io_latches();
      issue(OP_STO, ADDR_OUT);
      issue(OP_LAM, ADDR_OUT);
      issue(OP_LBM, ADDR_OUT);
      send_word(encode(OP_STO, ADDR_IN), 1'b1, 4'd15);
      issue(OP_LBM, ADDR_IN);
      issue(OP_STO, ADDR_IN);
      send_word(encode(OP_LAM, ADDR_IN), 1'b1, 4'd0);
      issue(OP_LBM, ADDR_IN);
   endtask

   // Conditional jump taken and not taken, counter wrap, plain jump.
   task automatic test_branches();
      issue(OP_LAI, 4'd3);
      issue(OP_JZ, 4'd9);
      issue(OP_LAI, 4'd0);
      issue(OP_JZ, 4'd15);
      issue(OP_ADD, 4'd0);
      issue(OP_JMP, 4'd7);
   endtask

   // Hold the receiver off while the sender keeps offering words, so the
   // result queue fills and the input side must stall.
   task automatic test_backpressure();
      steady_mode = 1'b1;
      hold_requests++;
      repeat (24) send_word(random_instruction(), 1'($urandom_range(0, 1)),
                            4'($urandom_range(0, 15)));
      steady_mode = 1'b0;
   endtask

   // Run random programs: each word is fetched from a random image at the
   // model's current pc, so jumps and loops behave like real code. The
   // first program runs with neither side idling.
   task automatic test_random_programs();
      logic [7:0] program_rom [16];
      for (int p = 0; p < 10; p++) begin
         steady_mode = (p == 0);
         foreach (program_rom[i]) program_rom[i] = random_instruction();
         repeat (40) send_word(program_rom[cpu.pc], 1'($urandom_range(0, 1)),
                               4'($urandom_range(0, 15)));
      end
      steady_mode = 1'b0;
   endtask

   // Unstructured words as noise after the programs.
   task automatic test_random_words();
      repeat (100) send_word(random_instruction(), 1'($urandom_range(0, 1)),
                             4'($urandom_range(0, 15)));
   endtask

   // Halt must advance pc and latch input once, then freeze everything.
   task automatic test_halt();
      send_word(encode(OP_HALT, 4'd0), 1'b1, 4'd5);
      issue(OP_JMP, 4'd3);
      send_word(encode(OP_LAI, 4'd9), 1'b1, 4'd12);
      issue(OP_STO, ADDR_OUT);
   endtask

   initial begin
      foreach (cpu_ram[i]) cpu_ram[i] = 4'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_arithmetic();
      test_logic();
      test_memory();
      test_io_latches();
      test_branches();
      test_backpressure();
      test_random_programs();
      test_random_words();
      // halt last: reset is never applied again, so nothing runs after it
      test_halt();
      // drop valid, drain, then let the result channel settle
      req_valid <= 1'b0;
      while (expected_states.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("Sent %0d instruction words (every opcode, I/O latches, jumps, halt).",
               words_sent);
      $display("Checked %0d result words, %0d output strobes, %0d mismatches.",
               results_checked, strobes_seen, mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[nibble_cpu_execute_step.f]
design/ncpu_pkg.sv
design/ncpu_datamem.sv
design/ncpu_exec.sv
design/ncpu_rsp_queue.sv
design/nibble_cpu_execute_step.sv
sim/tb_nibble_cpu_execute_step.sv
